[rtl/core/assert_macros.svh]
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/nrs_pkg.sv]
`default_nettype none

package nrs_pkg;

    localparam int MAX_RECTS  = 16;
    localparam int COORD_BITS = 12;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);

    localparam int ALPHA_W    = 9;
    localparam int RADIUS_W   = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    localparam int Q_BITS  = 8;
    localparam int Q_HALF  = 1 << (Q_BITS - 1);
    localparam int Q_ROUND = (1 << Q_BITS) - 1;

    localparam logic [ALPHA_W-1:0]  GAIN_FULL        = ALPHA_W'(1 << Q_BITS);
    localparam logic [ALPHA_W-1:0]  SIZE_GAIN_OFFSET = ALPHA_W'(51);
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET      = ALPHA_W'(128);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET     = RADIUS_W'(900);

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(1);

    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = SQ_W + 1;
    localparam int CMP_W   = (DIST_W > RADIUS_W) ? DIST_W : RADIUS_W;
    localparam int RECT_W  = 4 * COORD_BITS;
    localparam int TDATA_W = ((RECT_W + 7) / 8) * 8;

    // x in the lowest bits
    typedef struct packed {
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } rect_t;

    typedef struct packed {
        logic rotate;
        logic swap;
        logic write;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/nearest_rect_exponential_smoother_core.sv]
`default_nettype none

// Rectangle tracker with exponential smoothing. Each input transaction with
// has_rect set is matched against the previous frame's rectangles (up to
// MAX_RECTS) by squared top-left corner distance and yields one output
// transaction; an input without a rectangle yields nothing and, with tlast,
// closes the frame. The previous-frame store is a ring of MAX_RECTS cells that
// rotates once past a single distance unit for every rectangle, whatever the
// store holds, and no new input is taken while a rectangle is in flight. A
// finished result sits in the output register while the next input is taken.
// Configuration writes are meant for idle periods.
module nearest_rect_exponential_smoother_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [nrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [nrs_pkg::TDATA_W-1:0]     s_tdata,  // rect_x, rect_y, rect_w, rect_h
    input  wire logic [0:0]                      s_tuser,  // has_rect
    input  wire logic                            s_tlast,  // frame_last
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [nrs_pkg::TDATA_W-1:0]     m_tdata,  // out_x, out_y, out_w, out_h
    output logic      [1:0]                      m_tuser,  // matched, dropped
    output logic                                 m_tlast   // out_last
);
    import nrs_pkg::*;

    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_MULT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    prev_count_reg, prev_count_next;
    logic [CNT_W-1:0]    next_count_reg, next_count_next;
    logic [ALPHA_W-1:0]  alpha_reg, alpha_next;
    logic [RADIUS_W-1:0] radius_reg, radius_next;

    rect_t               in_rect_reg, in_rect_next;
    logic                in_last_reg, in_last_next;

    logic                p_act_reg, p_act_next;
    logic                p_hit_reg, p_hit_next;
    rect_t               p_rect_reg, p_rect_next;
    logic [SQ_W-1:0]     sqx_reg, sqx_next;
    logic [SQ_W-1:0]     sqy_reg, sqy_next;

    logic                found_reg, found_next;
    logic [DIST_W-1:0]   best_reg, best_next;
    rect_t               best_rect_reg, best_rect_next;

    logic                m_tvalid_reg, m_tvalid_next;
    rect_t               out_rect_reg, out_rect_next;
    logic                out_matched_reg, out_matched_next;
    logic                out_dropped_reg, out_dropped_next;
    logic                out_last_reg, out_last_next;

    logic                in_accept;
    logic                idle_swap;
    logic                rotate;
    logic                out_free;
    logic                fin_go;
    logic                room;
    logic                store_go;
    logic                swap_go;
    rect_t               s_rect;
    rect_t               head;
    rect_t               blended;
    rect_t               result_rect;
    logic [ALPHA_W-1:0]  pos_gain;
    logic [ALPHA_W-1:0]  size_gain;

    logic signed [COORD_BITS:0]     dx, dy;
    logic signed [2*COORD_BITS+1:0] sqx_full, sqy_full;
    logic [DIST_W-1:0]              dist_sum;
    logic                           in_range;
    logic                           closer;
    logic                           upd;

    rect_t     ring [MAX_RECTS];
    cell_ctl_t ctl  [MAX_RECTS];

    // handshake and control
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign s_rect    = rect_t'(s_tdata[RECT_W-1:0]);
    assign idle_swap = in_accept && !s_tuser[0] && s_tlast;
    assign rotate    = (state_reg == ST_SEARCH) && (idx_reg != CNT_W'(MAX_RECTS));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fin_go    = (state_reg == ST_FINISH) && out_free;
    assign room      = next_count_reg < CNT_W'(MAX_RECTS);
    assign store_go  = fin_go && room;
    assign swap_go   = idle_swap || (fin_go && in_last_reg);

    // store ring
    genvar g;
    generate
        for (g = 0; g < MAX_RECTS; g++) begin : g_cell
            assign ctl[g].rotate = rotate;
            assign ctl[g].swap   = swap_go;
            assign ctl[g].write  = store_go && (next_count_reg == CNT_W'(g));

            nrs_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl[g]),
                .rot_in   (ring[(g + 1) % MAX_RECTS]),
                .wr_data  (result_rect),
                .prev_out (ring[g])
            );
        end
    endgenerate

    assign head = ring[0];

    // distance, stage 1: squares
    always_comb begin
        dx          = $signed({1'b0, in_rect_reg.x}) - $signed({1'b0, head.x});
        dy          = $signed({1'b0, in_rect_reg.y}) - $signed({1'b0, head.y});
        sqx_full    = dx * dx;
        sqy_full    = dy * dy;
        sqx_next    = sqx_full[SQ_W-1:0];
        sqy_next    = sqy_full[SQ_W-1:0];
        p_act_next  = rotate;
        p_hit_next  = idx_reg < prev_count_reg;
        p_rect_next = head;
    end

    // distance, stage 2: compare and keep the earliest strict minimum
    always_comb begin
        dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        in_range = CMP_W'(dist_sum) < CMP_W'(radius_reg);
        closer   = !found_reg || (dist_sum < best_reg);
        upd      = p_act_reg && p_hit_reg && in_range && closer;
    end

    // gains
    always_comb begin
        pos_gain  = (alpha_reg > GAIN_FULL) ? GAIN_FULL : alpha_reg;
        size_gain = (pos_gain > SIZE_GAIN_OFFSET) ? (pos_gain - SIZE_GAIN_OFFSET) : '0;
    end

    nrs_blend u_blend_x (
        .aclk   (aclk),
        .load   (state_reg == ST_MULT),
        .stored (best_rect_reg.x),
        .fresh  (in_rect_reg.x),
        .gain   (pos_gain),
        .result (blended.x)
    );

    nrs_blend u_blend_y (
        .aclk   (aclk),
        .load   (state_reg == ST_MULT),
        .stored (best_rect_reg.y),
        .fresh  (in_rect_reg.y),
        .gain   (pos_gain),
        .result (blended.y)
    );

    nrs_blend u_blend_w (
        .aclk   (aclk),
        .load   (state_reg == ST_MULT),
        .stored (best_rect_reg.w),
        .fresh  (in_rect_reg.w),
        .gain   (size_gain),
        .result (blended.w)
    );

    nrs_blend u_blend_h (
        .aclk   (aclk),
        .load   (state_reg == ST_MULT),
        .stored (best_rect_reg.h),
        .fresh  (in_rect_reg.h),
        .gain   (size_gain),
        .result (blended.h)
    );

    assign result_rect = found_reg ? blended : in_rect_reg;

    // next-state logic
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        prev_count_next  = prev_count_reg;
        next_count_next  = next_count_reg;
        alpha_next       = alpha_reg;
        radius_next      = radius_reg;
        in_rect_next     = in_rect_reg;
        in_last_next     = in_last_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        best_rect_next   = best_rect_reg;
        out_rect_next    = out_rect_reg;
        out_matched_next = out_matched_reg;
        out_dropped_next = out_dropped_reg;
        out_last_next    = out_last_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALPHA:  alpha_next  = cfg_wdata[ALPHA_W-1:0];
                REG_RADIUS: radius_next = cfg_wdata[RADIUS_W-1:0];
                default: ;
            endcase
        end

        if (upd) begin
            found_next     = 1'b1;
            best_next      = dist_sum;
            best_rect_next = p_rect_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_tuser[0]) begin
                    state_next   = ST_SEARCH;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    in_rect_next = s_rect;
                    in_last_next = s_tlast;
                end
            end
            ST_SEARCH: begin
                if (idx_reg == CNT_W'(MAX_RECTS)) begin
                    state_next = ST_MULT;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_MULT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (fin_go) begin
                    state_next       = ST_IDLE;
                    m_tvalid_next    = 1'b1;
                    out_rect_next    = result_rect;
                    out_matched_next = found_reg;
                    out_dropped_next = !room;
                    out_last_next    = in_last_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (store_go) begin
            next_count_next = next_count_reg + CNT_W'(1);
        end
        if (swap_go) begin
            prev_count_next = next_count_reg + CNT_W'(store_go);
            next_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            prev_count_reg <= '0;
            next_count_reg <= '0;
            alpha_reg      <= ALPHA_RESET;
            radius_reg     <= RADIUS_RESET;
            p_act_reg      <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            prev_count_reg <= prev_count_next;
            next_count_reg <= next_count_next;
            alpha_reg      <= alpha_next;
            radius_reg     <= radius_next;
            p_act_reg      <= p_act_next;
            found_reg      <= found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_rect_reg     <= in_rect_next;
        in_last_reg     <= in_last_next;
        p_hit_reg       <= p_hit_next;
        p_rect_reg      <= p_rect_next;
        sqx_reg         <= sqx_next;
        sqy_reg         <= sqy_next;
        best_reg        <= best_next;
        best_rect_reg   <= best_rect_next;
        out_rect_reg    <= out_rect_next;
        out_matched_reg <= out_matched_next;
        out_dropped_reg <= out_dropped_next;
        out_last_reg    <= out_last_next;
    end

    // outputs
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(out_rect_reg);
    assign m_tuser  = {out_dropped_reg, out_matched_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_ALWAYS(a_reset_idle, aclk, (!aresetn) |=> (state_reg == ST_IDLE), "not idle after reset")
    `ASSERT_CLK(a_next_cnt, aclk, aresetn, next_count_reg <= CNT_W'(MAX_RECTS), "next count overflow")
    `ASSERT_CLK(a_prev_cnt, aclk, aresetn, prev_count_reg <= CNT_W'(MAX_RECTS), "prev count overflow")
    `ASSERT_CLK(a_search_len, aclk, aresetn, (state_reg == ST_MULT) |-> ($past(idx_reg) == CNT_W'(MAX_RECTS) && !p_act_reg), "search ended early")
    `ASSERT_CLK(a_best_range, aclk, aresetn, (state_reg == ST_FINISH && found_reg) |-> (CMP_W'(best_reg) < CMP_W'(radius_reg)), "match outside radius")

endmodule

`default_nettype wire

[rtl/core/nrs_cell.sv]
`default_nettype none

// One slot of the rectangle store: previous-frame entry on the rotating ring,
// current-frame entry filled in place and copied over at frame end.
module nrs_cell (
    input  wire logic              aclk,
    input  wire nrs_pkg::cell_ctl_t ctl,
    input  wire nrs_pkg::rect_t     rot_in,
    input  wire nrs_pkg::rect_t     wr_data,
    output nrs_pkg::rect_t          prev_out
);
    import nrs_pkg::*;

    rect_t prev_reg;
    rect_t prev_next;
    rect_t next_reg;
    rect_t next_next;

    always_comb begin
        prev_next = prev_reg;
        if (ctl.swap) begin
            prev_next = ctl.write ? wr_data : next_reg;
        end else if (ctl.rotate) begin
            prev_next = rot_in;
        end
        next_next = ctl.write ? wr_data : next_reg;
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        next_reg <= next_next;
    end

    assign prev_out = prev_reg;

endmodule

`default_nettype wire

[rtl/core/nrs_blend.sv]
`default_nettype none

// stored + round(gain * (fresh - stored) / 256), rounded half up then
// truncated toward zero, clamped to the coordinate range.
module nrs_blend (
    input  wire logic                           aclk,
    input  wire logic                           load,
    input  wire logic [nrs_pkg::COORD_BITS-1:0] stored,
    input  wire logic [nrs_pkg::COORD_BITS-1:0] fresh,
    input  wire logic [nrs_pkg::ALPHA_W-1:0]    gain,
    output logic      [nrs_pkg::COORD_BITS-1:0] result
);
    import nrs_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = ALPHA_W + 1 + DIFF_W;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic [COORD_BITS-1:0]     stored_reg;
    logic [COORD_BITS-1:0]     stored_next;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [PROD_W-1:0]  biased;
    logic signed [PROD_W-1:0]  step;
    logic signed [PROD_W-1:0]  stored_ext;
    logic signed [PROD_W-1:0]  sum;

    assign diff = $signed({1'b0, fresh}) - $signed({1'b0, stored});
    assign prod = $signed({1'b0, gain}) * diff;

    always_comb begin
        prod_next   = load ? prod : prod_reg;
        stored_next = load ? stored : stored_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        stored_reg <= stored_next;
    end

    always_comb begin
        rnd        = prod_reg + PROD_W'(Q_HALF);
        biased     = rnd[PROD_W-1] ? (rnd + PROD_W'(Q_ROUND)) : rnd;
        step       = biased >>> Q_BITS;
        stored_ext = $signed({{(PROD_W - COORD_BITS){1'b0}}, stored_reg});
        sum        = stored_ext + step;
        if (sum[PROD_W-1]) begin
            result = '0;
        end else if ($unsigned(sum) > PROD_W'(COORD_MAX)) begin
            result = '1;
        end else begin
            result = sum[COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire
